[rtl/two_d_rolling_hash_rect_query_macros.svh]
// Assertion macros for the checker file of the rectangle hash block.
`ifndef TWO_D_ROLLING_HASH_RECT_QUERY_MACROS_SVH
`define TWO_D_ROLLING_HASH_RECT_QUERY_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define RHQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define RHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rhq_pkg.sv]
// Package: moduli, bases, register codes and modular helper functions.
package rhq_pkg;

  localparam int HW = 30;

  localparam longint unsigned P0 = 64'd1000000007;
  localparam longint unsigned P1 = 64'd1000000009;

  localparam longint unsigned ROW_BASE0 = 64'd29;
  localparam longint unsigned ROW_BASE1 = 64'd31;
  localparam longint unsigned COL_BASE0 = 64'd37;
  localparam longint unsigned COL_BASE1 = 64'd41;

  // character offset: 'a' + 1 minus 2
  localparam logic [7:0] CHAR_OFS = 8'd96;

  localparam int DEF_MAX_ROWS = 128;
  localparam int DEF_MAX_COLS = 128;

  localparam logic [7:0] GRID_RST = 8'd128;

  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  typedef logic [HW-1:0] hval_t;

  // elaboration-time multiply mod P0 (k = 0) or P1 (k = 1)
  function automatic longint unsigned mul_mod_c(input logic k, input longint unsigned a,
                                                input longint unsigned b);
    longint unsigned t;
    t = a * b;
    if (k) return t % P1;
    else return t % P0;
  endfunction

  function automatic longint unsigned pow_mod_c(input logic k, input longint unsigned base,
                                                input longint unsigned e);
    longint unsigned r;
    longint unsigned a;
    longint unsigned n;
    r = 64'd1;
    a = base;
    n = e;
    while (n != 64'd0) begin
      if (n[0]) r = mul_mod_c(k, r, a);
      a = mul_mod_c(k, a, a);
      n = n >> 1;
    end
    return r;
  endfunction

  function automatic hval_t pow_entry(input logic k, input longint unsigned base,
                                      input int e);
    return hval_t'(pow_mod_c(k, base, longint'(e)));
  endfunction

  function automatic hval_t inv_pow_entry(input logic k, input longint unsigned base,
                                          input int e);
    longint unsigned ib;
    ib = pow_mod_c(k, base, (k ? P1 : P0) - 64'd2);
    return hval_t'(pow_mod_c(k, ib, longint'(e)));
  endfunction

  function automatic logic [HW:0] mod_of(input logic k);
    return k ? (HW+1)'(P1) : (HW+1)'(P0);
  endfunction

  function automatic hval_t add_mod(input logic k, input hval_t a, input hval_t b);
    logic [HW:0] t;
    logic [HW:0] p;
    p = mod_of(k);
    t = {1'b0, a} + {1'b0, b};
    return (t >= p) ? hval_t'(t - p) : hval_t'(t);
  endfunction

  function automatic hval_t sub_mod(input logic k, input hval_t a, input hval_t b);
    logic [HW:0] t;
    logic [HW:0] p;
    p = mod_of(k);
    t = {1'b0, a} + p - {1'b0, b};
    return (t >= p) ? hval_t'(t - p) : hval_t'(t);
  endfunction

endpackage

[rtl/rhq_modmul.sv]
// Bit-serial modular multiplier, one multiplier bit per cycle.
module rhq_modmul #(
  parameter longint unsigned P = rhq_pkg::P0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rhq_pkg::hval_t     a,
  input  rhq_pkg::hval_t     b,
  output logic               done,
  output rhq_pkg::hval_t     result
);
  import rhq_pkg::*;

  localparam int CW = $clog2(HW + 1);
  localparam logic [HW+1:0] PM  = (HW+2)'(P);
  localparam logic [HW+1:0] PM2 = (HW+2)'(2 * P);

  hval_t          acc_r, a_r, b_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [HW+1:0]  t;
  hval_t          acc_nxt;

  always_comb begin
    t = {1'b0, acc_r, 1'b0} + (b_r[HW-1] ? {2'b00, a_r} : '0);
    if (t >= PM2) acc_nxt = hval_t'(t - PM2);
    else if (t >= PM) acc_nxt = hval_t'(t - PM);
    else acc_nxt = hval_t'(t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(HW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[HW-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

[rtl/two_d_rolling_hash_rect_query.sv]
// Top level: 2-D double-modulus rolling hash, grid load and rectangle query.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid/in_stall, in_func, in_cell_*, | word in
//          | in_top_row ... in_right_col            |
//  out     | out_valid/out_stall, out_hash_first,   | word out
//          | out_hash_second, out_bad_range         |
//  cfg     | cfg_we, cfg_index, cfg_wdata           | write only
//
// One word at a time. A load holds in_stall through 3 prefix RAM reads, two
// dependent multiplies in the bit-serial mod units (30 bit steps each), a
// 3-step add/sub combine and the write; a query through 4 reads, the combine,
// the two multiplies and the result hand-off. Bad queries go straight to the
// hand-off; loads outside the grid are dropped at once.
// Synchronous active-low reset clears control only; the prefix RAM needs no
// clearing as border entries are never stored and read as zero.
// in_stall is high while a word is in work; a waiting result does not block
// the next word, only the hand-off of the next result.
module two_d_rolling_hash_rect_query #(
  parameter int MAX_ROWS = rhq_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = rhq_pkg::DEF_MAX_COLS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [7:0]       in_cell_byte,
  input  logic [7:0]       in_cell_row,
  input  logic [7:0]       in_cell_col,
  input  logic [7:0]       in_top_row,
  input  logic [7:0]       in_left_col,
  input  logic [7:0]       in_bottom_row,
  input  logic [7:0]       in_right_col,
  output logic             out_valid,
  input  logic             out_stall,
  output rhq_pkg::hval_t   out_hash_first,
  output rhq_pkg::hval_t   out_hash_second,
  output logic             out_bad_range
);
  import rhq_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RIW   = $clog2(MAX_ROWS + 1);
  localparam int CIW   = $clog2(MAX_COLS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_WT   = 4'd2;
  localparam logic [3:0] ST_M1S  = 4'd3;
  localparam logic [3:0] ST_M1W  = 4'd4;
  localparam logic [3:0] ST_M2S  = 4'd5;
  localparam logic [3:0] ST_M2W  = 4'd6;
  localparam logic [3:0] ST_CB   = 4'd7;
  localparam logic [3:0] ST_WR   = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  // constant power tables, one set per modulus
  hval_t row_pow     [2][MAX_ROWS+1];
  hval_t inv_row_pow [2][MAX_ROWS+1];
  hval_t col_pow     [2][MAX_COLS+1];
  hval_t inv_col_pow [2][MAX_COLS+1];

  // prefix RAM: interior entries only, {mod P1, mod P0}
  logic [2*HW-1:0] mem [DEPTH];
  logic [2*HW-1:0] mem_q_r;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;

  logic [3:0]      state_r, state_nxt;
  logic [7:0]      grid_rows_r, grid_cols_r;
  logic            func_r, bad_r;
  logic [7:0]      r_r, c_r, t_r, l_r;
  logic [7:0]      rr_r [4];
  logic [7:0]      cc_r [4];
  logic [1:0]      cnt_r;
  logic            rd_vld_r, rd_zero_r;
  logic [1:0]      rd_slot_r;
  logic [2*HW-1:0] ent_r [4];
  hval_t           s_r [2];
  hval_t           v_r [2];

  logic            out_valid_r, out_bad_r;
  hval_t           out_h0_r, out_h1_r;

  logic            mul_start;
  hval_t           mul_a [2];
  hval_t           mul_b [2];
  hval_t           mul_res [2];
  logic [1:0]      mul_done;
  logic            mul_fin;

  logic            in_acc, load_ok, q_bad, out_load, rd_last;

  function automatic logic [AW-1:0] ent_addr(input logic [7:0] row, input logic [7:0] col);
    return AW'((32'(row) - 32'd1) * MAX_COLS + 32'(col) - 32'd1);
  endfunction

  function automatic logic row_fits(input logic [7:0] x, input logic [7:0] lim);
    return (32'(x) <= MAX_ROWS) && (x <= lim);
  endfunction

  function automatic logic col_fits(input logic [7:0] x, input logic [7:0] lim);
    return (32'(x) <= MAX_COLS) && (x <= lim);
  endfunction

  for (genvar gk = 0; gk < 2; gk++) begin : g_mod
    for (genvar gi = 0; gi <= MAX_ROWS; gi++) begin : g_row
      assign row_pow[gk][gi]     = pow_entry(1'(gk), gk ? ROW_BASE1 : ROW_BASE0, gi);
      assign inv_row_pow[gk][gi] = inv_pow_entry(1'(gk), gk ? ROW_BASE1 : ROW_BASE0, gi);
    end
    for (genvar gi = 0; gi <= MAX_COLS; gi++) begin : g_col
      assign col_pow[gk][gi]     = pow_entry(1'(gk), gk ? COL_BASE1 : COL_BASE0, gi);
      assign inv_col_pow[gk][gi] = inv_pow_entry(1'(gk), gk ? COL_BASE1 : COL_BASE0, gi);
    end

    rhq_modmul #(.P(gk ? P1 : P0)) u_mul (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (mul_start),
      .a      (mul_a[gk]),
      .b      (mul_b[gk]),
      .done   (mul_done[gk]),
      .result (mul_res[gk])
    );
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign mul_fin  = &mul_done;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign rd_last  = (cnt_r == (func_r ? 2'd3 : 2'd2));

  assign load_ok = (in_cell_row != 8'd0) && (in_cell_col != 8'd0) &&
                   row_fits(in_cell_row, grid_rows_r) && col_fits(in_cell_col, grid_cols_r);
  assign q_bad   = (in_top_row == 8'd0) || (in_left_col == 8'd0) ||
                   (in_top_row > in_bottom_row) || (in_left_col > in_right_col) ||
                   !row_fits(in_bottom_row, grid_rows_r) ||
                   !col_fits(in_right_col, grid_cols_r);

  // multiplier operands: first pass takes cell value or combined sum
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (state_r == ST_M1S) begin
        mul_a[k] = func_r ? s_r[k] : v_r[k];
        mul_b[k] = func_r ? inv_row_pow[k][RIW'(t_r - 8'd1)] : row_pow[k][RIW'(r_r)];
      end else begin
        mul_a[k] = mul_res[k];
        mul_b[k] = func_r ? inv_col_pow[k][CIW'(l_r - 8'd1)] : col_pow[k][CIW'(c_r)];
      end
    end
  end
  assign mul_start = (state_r == ST_M1S) || (state_r == ST_M2S);

  assign rd_en   = (state_r == ST_RD);
  assign rd_addr = ent_addr(rr_r[cnt_r], cc_r[cnt_r]);
  assign wr_en   = (state_r == ST_WR);
  assign wr_addr = ent_addr(r_r, c_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {s_r[1], s_r[0]};
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func) state_nxt = q_bad ? ST_OUT : ST_RD;
          else if (load_ok) state_nxt = ST_RD;
        end
      end
      ST_RD:   if (rd_last) state_nxt = ST_WT;
      ST_WT:   state_nxt = func_r ? ST_CB : ST_M1S;
      ST_M1S:  state_nxt = ST_M1W;
      ST_M1W:  if (mul_fin) state_nxt = ST_M2S;
      ST_M2S:  state_nxt = ST_M2W;
      ST_M2W:  if (mul_fin) state_nxt = func_r ? ST_OUT : ST_CB;
      ST_CB:   if (cnt_r == 2'd2) state_nxt = func_r ? ST_M1S : ST_WR;
      ST_WR:   state_nxt = ST_IDLE;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grid_rows_r <= GRID_RST;
      grid_cols_r <= GRID_RST;
      cnt_r       <= 2'd0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
          REG_GRID_COLS: grid_cols_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == ST_RD && rd_last) || (state_r == ST_CB && cnt_r == 2'd2)) cnt_r <= 2'd0;
      else if (state_r == ST_RD || state_r == ST_CB) cnt_r <= cnt_r + 2'd1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      bad_r  <= in_func & q_bad;
      r_r    <= in_cell_row;
      c_r    <= in_cell_col;
      t_r    <= in_top_row;
      l_r    <= in_left_col;
      for (int k = 0; k < 2; k++) begin
        // byte - 96 lifted into [0,p)
        v_r[k] <= (in_cell_byte >= CHAR_OFS) ? hval_t'(in_cell_byte - CHAR_OFS) :
                  hval_t'(mod_of(1'(k)) + (HW+1)'(in_cell_byte) - (HW+1)'(CHAR_OFS));
      end
      if (in_func) begin
        rr_r[0] <= in_bottom_row;        cc_r[0] <= in_right_col;
        rr_r[1] <= in_top_row - 8'd1;    cc_r[1] <= in_right_col;
        rr_r[2] <= in_bottom_row;        cc_r[2] <= in_left_col - 8'd1;
        rr_r[3] <= in_top_row - 8'd1;    cc_r[3] <= in_left_col - 8'd1;
      end else begin
        rr_r[0] <= in_cell_row - 8'd1;   cc_r[0] <= in_cell_col;
        rr_r[1] <= in_cell_row;          cc_r[1] <= in_cell_col - 8'd1;
        rr_r[2] <= in_cell_row - 8'd1;   cc_r[2] <= in_cell_col - 8'd1;
        rr_r[3] <= 8'd0;                 cc_r[3] <= 8'd0;
      end
    end

    rd_slot_r <= cnt_r;
    rd_zero_r <= (rr_r[cnt_r] == 8'd0) || (cc_r[cnt_r] == 8'd0);
    if (rd_vld_r) ent_r[rd_slot_r] <= rd_zero_r ? '0 : mem_q_r;
    else if (state_r == ST_M2W && mul_fin && !func_r) ent_r[3] <= {mul_res[1], mul_res[0]};

    // combine: e0 +/- e1, - e2, + e3
    if (state_r == ST_CB) begin
      for (int k = 0; k < 2; k++) begin
        unique case (cnt_r)
          2'd0: s_r[k] <= func_r ? sub_mod(1'(k), ent_r[0][k*HW +: HW], ent_r[1][k*HW +: HW])
                                 : add_mod(1'(k), ent_r[0][k*HW +: HW], ent_r[1][k*HW +: HW]);
          2'd1: s_r[k] <= sub_mod(1'(k), s_r[k], ent_r[2][k*HW +: HW]);
          2'd2: s_r[k] <= add_mod(1'(k), s_r[k], ent_r[3][k*HW +: HW]);
          default: s_r[k] <= s_r[k];
        endcase
      end
    end

    if (out_load) begin
      out_bad_r <= bad_r;
      out_h0_r  <= bad_r ? '0 : mul_res[0];
      out_h1_r  <= bad_r ? '0 : mul_res[1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hash_first  = out_h0_r;
  assign out_hash_second = out_h1_r;
  assign out_bad_range   = out_bad_r;

endmodule

[rtl/rhq_checker.sv]
// Port-level checker for the rectangle hash block, with its bind.
`include "two_d_rolling_hash_rect_query_macros.svh"

module rhq_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_func,
  input logic             out_valid,
  input logic             out_stall,
  input rhq_pkg::hval_t   out_hash_first,
  input rhq_pkg::hval_t   out_hash_second,
  input logic             out_bad_range
);
  import rhq_pkg::*;

  `RHQ_ASSERT_NOW(a_bad_zero, out_valid && out_bad_range, out_hash_first == '0 && out_hash_second == '0, "bad range word with non-zero hash")
  `RHQ_ASSERT_NOW(a_hash_reduced, out_valid && !out_bad_range, 64'(out_hash_first) < P0 && 64'(out_hash_second) < P1, "hash not reduced")
  `RHQ_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && in_func, in_stall, "query taken without going busy")
  `RHQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hash_first) && $stable(out_hash_second), "stalled result changed")

endmodule

bind two_d_rolling_hash_rect_query rhq_checker u_rhq_checker (.*);

[tb/sv/two_d_rolling_hash_rect_query_tb.sv]
// Testbench for the 2-D double-modulus rectangle hash block: directed table, then random phases.
`timescale 1ns / 1ps

module two_d_rolling_hash_rect_query_tb;
  import rhq_pkg::*;

  localparam int GRID_MAX     = 128;
  localparam int RANDOM_WORDS = 1850;
  localparam int STALL_LIMIT  = 20000;
  localparam int SETTLE       = 150;  // a load leaves no result to wait for

  localparam logic FN_LOAD  = 1'b0;
  localparam logic FN_QUERY = 1'b1;

  typedef struct {
    logic       func;
    logic [7:0] cbyte, crow, ccol, top_r, left_c, bot_r, right_c;
    bit         typed;       // expected result written in by hand
    hval_t      h0, h1;
    logic       bad;
  } word_t;

  typedef struct {
    hval_t h0, h1;
    logic  bad;
  } hash_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_GRID_ROWS;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_func = FN_LOAD;
  logic [7:0] in_cell_byte = 8'd0, in_cell_row = 8'd0, in_cell_col = 8'd0;
  logic [7:0] in_top_row = 8'd0, in_left_col = 8'd0, in_bottom_row = 8'd0;
  logic [7:0] in_right_col = 8'd0;
  logic       out_stall = 1'b0;
  logic       in_stall, out_valid, out_bad_range;
  hval_t      out_hash_first, out_hash_second;

  always #2 clk = ~clk;

  two_d_rolling_hash_rect_query dut (.*);

  // ---- prediction state ----
  longint unsigned prefix_sum [2][0:GRID_MAX][0:GRID_MAX];
  longint unsigned rpow [2][0:GRID_MAX], cpow [2][0:GRID_MAX];
  longint unsigned irpow[2][0:GRID_MAX], icpow[2][0:GRID_MAX];
  bit              loaded [0:GRID_MAX][0:GRID_MAX];  // entry holds a defined value
  logic [15:0]     loaded_cells[$];
  int unsigned     rows_set = GRID_RST, cols_set = GRID_RST;

  hash_t pending_hashes[$];
  int    mismatches = 0, n_words = 0, n_results = 0, n_bad = 0, n_phases = 0;
  int    tx_pct = 0, rx_pct = 0;
  int    quiet = 0;

  function automatic longint unsigned modulus(int k);
    return k ? P1 : P0;
  endfunction

  function automatic longint unsigned mulm(longint unsigned a, longint unsigned b, int k);
    return (a * b) % modulus(k);
  endfunction

  function automatic longint unsigned expm(longint unsigned a, longint unsigned e, int k);
    longint unsigned acc;
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = mulm(acc, a, k);
      a = mulm(a, a, k);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic int unsigned rows_eff();
    return rows_set < GRID_MAX ? rows_set : GRID_MAX;
  endfunction

  function automatic int unsigned cols_eff();
    return cols_set < GRID_MAX ? cols_set : GRID_MAX;
  endfunction

  function automatic bit load_ok(int r, int c);
    return loaded[r-1][c] && loaded[r][c-1] && loaded[r-1][c-1];
  endfunction

  function automatic bit rect_ok(int t, int l, int b, int r);
    return loaded[b][r] && loaded[t-1][r] && loaded[b][l-1] && loaded[t-1][l-1];
  endfunction

  function automatic bit rect_bad(word_t w);
    return w.top_r == 0 || w.left_c == 0 || w.top_r > w.bot_r || w.left_c > w.right_c ||
           w.bot_r > rows_eff() || w.right_c > cols_eff();
  endfunction

  // Advance the predicted table by one accepted word; returns 1 when a result follows.
  function automatic bit hash_word(word_t w, output hash_t res);
    longint unsigned p, v, s;
    int r, c, t, l, b, rr;
    res = '{default: '0};
    if (w.func == FN_LOAD) begin
      r = int'(w.crow); c = int'(w.ccol);
      if (r == 0 || c == 0 || r > rows_eff() || c > cols_eff()) return 0;
      for (int k = 0; k < 2; k++) begin
        p = modulus(k);
        v = (longint'(w.cbyte) + p - longint'(CHAR_OFS)) % p;
        v = mulm(mulm(v, rpow[k][r], k), cpow[k][c], k);
        s = (prefix_sum[k][r-1][c] + prefix_sum[k][r][c-1]) % p;
        s = (s + p - prefix_sum[k][r-1][c-1]) % p;
        prefix_sum[k][r][c] = (s + v) % p;
      end
      if (!loaded[r][c]) begin
        loaded[r][c] = 1'b1;
        loaded_cells.push_back({8'(r), 8'(c)});
      end
      return 0;
    end
    if (rect_bad(w)) begin
      res.bad = 1'b1;
      return 1;
    end
    t = int'(w.top_r); l = int'(w.left_c); b = int'(w.bot_r); rr = int'(w.right_c);
    for (int k = 0; k < 2; k++) begin
      p = modulus(k);
      s = (prefix_sum[k][b][rr] + p - prefix_sum[k][t-1][rr]) % p;
      s = (s + p - prefix_sum[k][b][l-1]) % p;
      s = (s + prefix_sum[k][t-1][l-1]) % p;
      s = mulm(mulm(s, irpow[k][t-1], k), icpow[k][l-1], k);
      if (k == 0) res.h0 = hval_t'(s);
      else res.h1 = hval_t'(s);
    end
    return 1;
  endfunction

  initial begin
    longint unsigned ir, ic;
    for (int k = 0; k < 2; k++) begin
      ir = expm(k ? ROW_BASE1 : ROW_BASE0, modulus(k) - 2, k);
      ic = expm(k ? COL_BASE1 : COL_BASE0, modulus(k) - 2, k);
      rpow[k][0] = 1; cpow[k][0] = 1; irpow[k][0] = 1; icpow[k][0] = 1;
      for (int i = 1; i <= GRID_MAX; i++) begin
        rpow[k][i]  = mulm(rpow[k][i-1], k ? ROW_BASE1 : ROW_BASE0, k);
        cpow[k][i]  = mulm(cpow[k][i-1], k ? COL_BASE1 : COL_BASE0, k);
        irpow[k][i] = mulm(irpow[k][i-1], ir, k);
        icpow[k][i] = mulm(icpow[k][i-1], ic, k);
      end
      for (int i = 0; i <= GRID_MAX; i++)
        for (int j = 0; j <= GRID_MAX; j++) prefix_sum[k][i][j] = 0;
    end
    // border row and column read as zero
    for (int i = 0; i <= GRID_MAX; i++)
      for (int j = 0; j <= GRID_MAX; j++) loaded[i][j] = (i == 0 || j == 0);
  end

  // ---- receiver: random stall, result check ----
  always @(negedge clk) out_stall <= ($urandom_range(99) < rx_pct);

  always @(posedge clk) begin
    hash_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result word with nothing expected");
      end else begin
        e = pending_hashes.pop_front();
        if (e.h0 !== out_hash_first || e.h1 !== out_hash_second || e.bad !== out_bad_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: hash exp %0d/%0d bad %0b, got %0d/%0d bad %0b",
                     e.h0, e.h1, e.bad, out_hash_first, out_hash_second, out_bad_range);
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("ERROR: timeout, no word moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- sender ----
  task automatic send_word(word_t w);
    hash_t res;
    @(negedge clk);
    while ($urandom_range(99) < tx_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func = w.func; in_cell_byte = w.cbyte; in_cell_row = w.crow; in_cell_col = w.ccol;
    in_top_row = w.top_r; in_left_col = w.left_c; in_bottom_row = w.bot_r;
    in_right_col = w.right_c;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_words++;
    if (hash_word(w, res)) begin
      if (w.typed) begin
        res.h0 = w.h0; res.h1 = w.h1; res.bad = w.bad;
      end
      n_bad += res.bad;
      pending_hashes.push_back(res);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_GRID_ROWS) rows_set = 32'(val);
    else cols_set = 32'(val);
  endtask

  function automatic word_t load_w(int r, int c, int b);
    word_t w;
    w = '{default: '0};
    w.func = FN_LOAD; w.crow = 8'(r); w.ccol = 8'(c); w.cbyte = 8'(b);
    w.top_r = 8'($urandom); w.left_c = 8'($urandom);
    w.bot_r = 8'($urandom); w.right_c = 8'($urandom);
    return w;
  endfunction

  function automatic word_t query_w(int t, int l, int b, int r);
    word_t w;
    w = '{default: '0};
    w.func = FN_QUERY; w.top_r = 8'(t); w.left_c = 8'(l); w.bot_r = 8'(b); w.right_c = 8'(r);
    w.cbyte = 8'($urandom); w.crow = 8'($urandom); w.ccol = 8'($urandom);
    return w;
  endfunction

  function automatic word_t bad_w(int t, int l, int b, int r);
    word_t w;
    w = query_w(t, l, b, r);
    w.typed = 1'b1; w.bad = 1'b1;
    return w;
  endfunction

  // rectangle whose four corner entries are all defined, else a reversed one
  function automatic word_t random_rect();
    logic [15:0] pos;
    int b, r, t, l;
    for (int tries = 0; tries < 60; tries++) begin
      pos = loaded_cells[$urandom_range(loaded_cells.size() - 1)];
      b = int'(pos[15:8]); r = int'(pos[7:0]);
      if (b <= rows_eff() && r <= cols_eff()) begin
        t = $urandom_range(b, 1); l = $urandom_range(r, 1);
        if (rect_ok(t, l, b, r)) return query_w(t, l, b, r);
      end
    end
    return query_w(2, 1, 1, 1);
  endfunction

  // random fields; anything that would read an undefined entry is turned into a dropped load or a bad query
  function automatic word_t noise_w();
    word_t w;
    w = query_w($urandom, $urandom, $urandom, $urandom);
    w.func = 1'($urandom);
    if (w.func == FN_LOAD) begin
      if (w.crow != 0 && w.ccol != 0 && w.crow <= rows_eff() && w.ccol <= cols_eff() &&
          !load_ok(int'(w.crow), int'(w.ccol))) w.crow = 8'd0;
    end else if (!rect_bad(w) &&
                 !rect_ok(int'(w.top_r), int'(w.left_c), int'(w.bot_r), int'(w.right_c))) begin
      w.top_r = 8'd0;
    end
    return w;
  endfunction

  word_t directed[$];
  word_t w;

  initial begin
    int r_sz, c_sz, mode, n_random, n_mix;
    logic [15:0] pos;

    // directed table, grid at its reset size
    directed = '{
      bad_w(0, 1, 1, 1), bad_w(1, 0, 1, 1), bad_w(3, 1, 2, 1), bad_w(1, 5, 1, 4),
      bad_w(1, 1, 129, 1), bad_w(1, 1, 1, 255), bad_w(255, 1, 1, 1), bad_w(1, 200, 1, 1),
      load_w(0, 1, 8'h61), load_w(1, 0, 8'h61), load_w(129, 5, 8'h61),
      load_w(255, 255, 8'hff),
      load_w(1, 1, 8'h61), query_w(1, 1, 1, 1),
      load_w(1, 2, 8'h00), load_w(2, 1, 8'hff), load_w(2, 2, 8'h60),
      query_w(1, 1, 2, 2), query_w(2, 2, 2, 2), query_w(1, 2, 2, 2),
      load_w(1, 1, 8'h80), query_w(1, 1, 2, 2), query_w(2, 1, 2, 2)
    };
    // 'a' weighs 1: hash of that single cell is just the two base products
    directed[13].typed = 1'b1;
    directed[13].h0 = 30'd1073; directed[13].h1 = 30'd1271; directed[13].bad = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_word(directed[i]);
    n_phases++;

    // random phases: fill the grid in row-major order, or strips along row 1 and column 1, then mixed traffic
    n_random = 0;
    for (int ph = 0; n_random < RANDOM_WORDS; ph++) begin
      mode = ph % 5;
      case (ph)
        0: begin r_sz = 128; c_sz = 128; end  // long strips along row 1 and column 1
        2: begin r_sz = 0;   c_sz = 5;   end  // zero-size grid
        3: begin r_sz = 255; c_sz = 255; end  // clipped to the maximum, strips again
        default: begin
          r_sz = $urandom_range(10, 1); c_sz = $urandom_range(10, 1);
        end
      endcase
      write_reg(REG_GRID_ROWS, 8'(r_sz));
      write_reg(REG_GRID_COLS, 8'(c_sz));
      // idle pattern for this phase
      case (mode)
        1: begin tx_pct = 74; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 74; end
        3: begin tx_pct = 37; rx_pct = 37; end
        default: begin tx_pct = 0; rx_pct = 0; end
      endcase
      n_phases++;

      if (ph == 0 || ph == 3) begin
        for (int c = 1; c <= 128; c++) send_word(load_w(1, c, $urandom));
        for (int r = 2; r <= 128; r++) send_word(load_w(r, 1, $urandom));
        n_random += 255;
      end else begin
        for (int r = 1; r <= rows_eff(); r++)
          for (int c = 1; c <= cols_eff(); c++) begin
            send_word(load_w(r, c, $urandom));
            n_random++;
          end
      end

      n_mix = (ph == 2) ? 20 : 60;
      for (int i = 0; i < n_mix; i++) begin
        // hold off halfway until every pending hash is back
        if (i == n_mix / 2) drain();
        case ($urandom_range(9))
          0: w = noise_w();
          1, 2: begin
            pos = loaded_cells[$urandom_range(loaded_cells.size() - 1)];
            w = load_w(int'(pos[15:8]), int'(pos[7:0]), $urandom);
            if (pos[15:8] > rows_eff() || pos[7:0] > cols_eff()) w = random_rect();
          end
          default: w = random_rect();
        endcase
        send_word(w);
        n_random++;
      end
    end

    tx_pct = 0; rx_pct = 0;
    drain();
    repeat (SETTLE) @(posedge clk);
    if (pending_hashes.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d expected hashes never arrived", pending_hashes.size());
    end
    $display("Run covered %0d words over %0d phases, %0d query results (%0d out of range).",
             n_words, n_phases, n_results, n_bad);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
